// ===== src/sca_pkg.sv =====
`default_nettype none
package sca_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int PARAM_W    = 24;
    localparam int GAP_W      = 25;

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 2;
    localparam int BW   = 2 * SW;
    localparam int NW   = BW + 2;
    localparam int DVW  = (NW + FRAC_BITS > BW + PARAM_W) ? NW + FRAC_BITS : BW + PARAM_W;
    localparam int MW   = DW + FRAC_BITS + 1;
    localparam int PTW  = COORD_BITS + FRAC_BITS + 1;
    localparam int SQW  = 2 * PTW + 2;
    localparam int SH   = 2 * FRAC_BITS - 16;
    localparam int RADW = SQW - SH;
    localparam int RTW  = (RADW + 1) / 2;
    localparam int RMW  = 2 * RTW + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         dvec_t;
    typedef logic signed [PARAM_W-1:0]    param_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_start_z;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t a_end_z;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_start_z;
        coord_t b_end_x;
        coord_t b_end_y;
        coord_t b_end_z;
    } seg_pair_t;

    typedef struct packed {
        coord_t [2:0] o1;
        coord_t [2:0] o2;
        dvec_t  [2:0] d1;
        dvec_t  [2:0] d2;
    } geom_t;

    typedef struct packed {
        geom_t                geom;
        logic [BW-1:0]        den;
        logic signed [NW-1:0] num_s;
        logic signed [NW-1:0] num_t;
    } dot_out_t;

    typedef struct packed {
        geom_t  geom;
        param_t param_a;
        param_t param_b;
        logic   parallel;
    } div_out_t;

    typedef struct packed {
        param_t             param_a;
        param_t             param_b;
        logic [GAP_W-1:0]   gap_length;
        logic               parallel;
    } result_t;

endpackage
`default_nettype wire

// ===== src/sca_if.sv =====
`default_nettype none
interface sca_seg_if;
    import sca_pkg::*;
    logic   valid;
    logic   ready;
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );
endinterface

interface sca_res_if;
    import sca_pkg::*;
    logic               valid;
    logic               ready;
    param_t             param_a;
    param_t             param_b;
    logic [GAP_W-1:0]   gap_length;
    logic               parallel;

    modport source (
        output valid, param_a, param_b, gap_length, parallel,
        input  ready
    );
    modport sink (
        input  valid, param_a, param_b, gap_length, parallel,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/segment_closest_approach_top.sv =====
`default_nettype none
// An accepted item passes through the dot product stages, then restoring division
// (one quotient bit per stage), then clamping, distance and square root
// (one root bit per stage) before its result appears.
// Throughput is one item per cycle; a stage holds while the next one cannot accept.
// Reset clears only the valid bits of the pipeline; no item is in flight after reset.
module segment_closest_approach_top (
    input wire        clk,
    input wire        rst_n,
    sca_seg_if.sink   segs,
    sca_res_if.source result
);
    import sca_pkg::*;

    seg_pair_t seg_data;
    logic      dot_valid;
    logic      dot_ready;
    dot_out_t  dot_data;
    logic      div_valid;
    logic      div_ready;
    div_out_t  div_data;
    result_t   res_data;

    always_comb
    begin
        seg_data.a_start_x = segs.a_start_x;
        seg_data.a_start_y = segs.a_start_y;
        seg_data.a_start_z = segs.a_start_z;
        seg_data.a_end_x   = segs.a_end_x;
        seg_data.a_end_y   = segs.a_end_y;
        seg_data.a_end_z   = segs.a_end_z;
        seg_data.b_start_x = segs.b_start_x;
        seg_data.b_start_y = segs.b_start_y;
        seg_data.b_start_z = segs.b_start_z;
        seg_data.b_end_x   = segs.b_end_x;
        seg_data.b_end_y   = segs.b_end_y;
        seg_data.b_end_z   = segs.b_end_z;
    end

    sca_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (segs.valid),
        .in_ready  (segs.ready),
        .in_data   (seg_data),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_data  (dot_data)
    );

    sca_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_data   (dot_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    sca_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res_data)
    );

    assign result.param_a    = res_data.param_a;
    assign result.param_b    = res_data.param_b;
    assign result.gap_length = res_data.gap_length;
    assign result.parallel   = res_data.parallel;

endmodule
`default_nettype wire

// ===== src/sca_dot.sv =====
`default_nettype none
module sca_dot (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire sca_pkg::seg_pair_t in_data,
    output logic                    out_valid,
    input  wire                     out_ready,
    output sca_pkg::dot_out_t       out_data
);
    import sca_pkg::*;

    localparam int NS  = 5;
    localparam int A11 = 0;
    localparam int A22 = 1;
    localparam int A12 = 2;
    localparam int V1  = 3;
    localparam int V2  = 4;

    logic [NS-1:0]        valid_reg;
    logic [NS:0]          en;
    geom_t                geom_in;
    geom_t                geom_reg [NS];
    dvec_t                v0_reg [3];
    logic signed [PW-1:0] prod_reg [5][3];
    logic signed [SW-1:0] sum_reg [5];
    logic signed [BW-1:0] big_reg [6];
    logic [BW-1:0]        den_reg;
    logic signed [NW-1:0] num_s_reg;
    logic signed [NW-1:0] num_t_reg;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_comb
    begin
        geom_in.o1 = {in_data.a_start_z, in_data.a_start_y, in_data.a_start_x};
        geom_in.o2 = {in_data.b_start_z, in_data.b_start_y, in_data.b_start_x};
        geom_in.d1[0] = DW'(in_data.a_end_x) - DW'(in_data.a_start_x);
        geom_in.d1[1] = DW'(in_data.a_end_y) - DW'(in_data.a_start_y);
        geom_in.d1[2] = DW'(in_data.a_end_z) - DW'(in_data.a_start_z);
        geom_in.d2[0] = DW'(in_data.b_end_x) - DW'(in_data.b_start_x);
        geom_in.d2[1] = DW'(in_data.b_end_y) - DW'(in_data.b_start_y);
        geom_in.d2[2] = DW'(in_data.b_end_z) - DW'(in_data.b_start_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            geom_reg[0] <= geom_in;
            for (int i = 0; i < 3; i++)
            begin
                v0_reg[i] <= DW'($signed(geom_in.o2[i])) - DW'($signed(geom_in.o1[i]));
            end
        end
        if (en[1])
        begin
            geom_reg[1] <= geom_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[A11][i] <= PW'($signed(geom_reg[0].d1[i]))
                                  * PW'($signed(geom_reg[0].d1[i]));
                prod_reg[A22][i] <= PW'($signed(geom_reg[0].d2[i]))
                                  * PW'($signed(geom_reg[0].d2[i]));
                prod_reg[A12][i] <= PW'($signed(geom_reg[0].d1[i]))
                                  * PW'($signed(geom_reg[0].d2[i]));
                prod_reg[V1][i]  <= PW'(v0_reg[i]) * PW'($signed(geom_reg[0].d1[i]));
                prod_reg[V2][i]  <= PW'(v0_reg[i]) * PW'($signed(geom_reg[0].d2[i]));
            end
        end
        if (en[2])
        begin
            geom_reg[2] <= geom_reg[1];
            for (int j = 0; j < 5; j++)
            begin
                sum_reg[j] <= SW'(prod_reg[j][0]) + SW'(prod_reg[j][1]) + SW'(prod_reg[j][2]);
            end
        end
        if (en[3])
        begin
            geom_reg[3] <= geom_reg[2];
            big_reg[0]  <= BW'(sum_reg[A11]) * BW'(sum_reg[A22]);
            big_reg[1]  <= BW'(sum_reg[A12]) * BW'(sum_reg[A12]);
            big_reg[2]  <= BW'(sum_reg[V1]) * BW'(sum_reg[A22]);
            big_reg[3]  <= BW'(sum_reg[V2]) * BW'(sum_reg[A12]);
            big_reg[4]  <= BW'(sum_reg[V1]) * BW'(sum_reg[A12]);
            big_reg[5]  <= BW'(sum_reg[V2]) * BW'(sum_reg[A11]);
        end
        if (en[4])
        begin
            geom_reg[4] <= geom_reg[3];
            den_reg     <= big_reg[0] - big_reg[1];
            num_s_reg   <= NW'(big_reg[2]) - NW'(big_reg[3]);
            num_t_reg   <= NW'(big_reg[4]) - NW'(big_reg[5]);
        end
    end

    always_comb
    begin
        out_data.geom  = geom_reg[NS-1];
        out_data.den   = den_reg;
        out_data.num_s = num_s_reg;
        out_data.num_t = num_t_reg;
    end

endmodule
`default_nettype wire

// ===== src/sca_div.sv =====
`default_nettype none
module sca_div (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire sca_pkg::dot_out_t in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output sca_pkg::div_out_t      out_data
);
    import sca_pkg::*;

    localparam int QW = PARAM_W;
    localparam int NS = QW + 3;

    typedef struct packed {
        geom_t              geom;
        logic [BW-1:0]      den;
        logic               par;
        logic               neg_s;
        logic               neg_t;
        logic               ovf_s;
        logic               ovf_t;
        logic [DVW-1:0]     rem_s;
        logic [DVW-1:0]     rem_t;
        logic [QW-1:0]      q_s;
        logic [QW-1:0]      q_t;
        param_t             pa;
        param_t             pb;
    } div_stage_t;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;
    div_stage_t    st_reg  [NS];
    div_stage_t    st_next [NS];

    function automatic param_t sat_q(input logic neg, input logic ovf, input logic [QW-1:0] q);
        param_t r;
        if (!neg)
        begin
            r = (ovf || q[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : q;
        end
        else if (ovf || (q[QW-1] && (q[QW-2:0] != '0)))
        begin
            r = {1'b1, {(QW-1){1'b0}}};
        end
        else
        begin
            r = -q;
        end
        return r;
    endfunction

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_comb
    begin
        logic [NW-1:0]  mag_s;
        logic [NW-1:0]  mag_t;
        logic [DVW-1:0] sh;
        mag_s = in_data.num_s[NW-1] ? NW'(-in_data.num_s) : NW'(in_data.num_s);
        mag_t = in_data.num_t[NW-1] ? NW'(-in_data.num_t) : NW'(in_data.num_t);
        st_next[0]       = '0;
        st_next[0].geom  = in_data.geom;
        st_next[0].den   = in_data.den;
        st_next[0].par   = (in_data.den == '0);
        st_next[0].neg_s = in_data.num_s[NW-1];
        st_next[0].neg_t = in_data.num_t[NW-1];
        st_next[0].rem_s = DVW'(mag_s) << FRAC_BITS;
        st_next[0].rem_t = DVW'(mag_t) << FRAC_BITS;
        for (int k = 1; k < NS; k++)
        begin
            st_next[k] = st_reg[k-1];
            if (k == 1)
            begin
                sh = DVW'(st_reg[k-1].den) << QW;
                st_next[k].ovf_s = (st_reg[k-1].rem_s >= sh);
                st_next[k].ovf_t = (st_reg[k-1].rem_t >= sh);
            end
            else if (k < NS - 1)
            begin
                sh = DVW'(st_reg[k-1].den) << (QW + 1 - k);
                if (st_reg[k-1].rem_s >= sh)
                begin
                    st_next[k].rem_s        = st_reg[k-1].rem_s - sh;
                    st_next[k].q_s[QW+1-k]  = 1'b1;
                end
                if (st_reg[k-1].rem_t >= sh)
                begin
                    st_next[k].rem_t        = st_reg[k-1].rem_t - sh;
                    st_next[k].q_t[QW+1-k]  = 1'b1;
                end
            end
            else
            begin
                st_next[k].pa = st_reg[k-1].par ? '0
                              : sat_q(st_reg[k-1].neg_s, st_reg[k-1].ovf_s, st_reg[k-1].q_s);
                st_next[k].pb = st_reg[k-1].par ? '0
                              : sat_q(st_reg[k-1].neg_t, st_reg[k-1].ovf_t, st_reg[k-1].q_t);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_comb
    begin
        out_data.geom     = st_reg[NS-1].geom;
        out_data.param_a  = st_reg[NS-1].pa;
        out_data.param_b  = st_reg[NS-1].pb;
        out_data.parallel = st_reg[NS-1].par;
    end

endmodule
`default_nettype wire

// ===== src/sca_dist.sv =====
`default_nettype none
module sca_dist (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire sca_pkg::div_out_t in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output sca_pkg::result_t       out_data
);
    import sca_pkg::*;

    localparam int NS   = RTW + 6;
    localparam int CLW  = PARAM_W + FRAC_BITS + 1;
    localparam int DFW  = MW + 2;
    localparam int GXW  = RTW + GAP_W;
    localparam logic signed [CLW-1:0] ONE_W = CLW'(1) << FRAC_BITS;
    localparam logic [GAP_W-1:0]      GMAX  = {GAP_W{1'b1}};

    typedef logic signed [MW-1:0]  mprod_t;
    typedef logic signed [PTW-1:0] diff_t;

    typedef struct packed {
        param_t                  pa;
        param_t                  pb;
        logic                    par;
        geom_t                   geom;
        logic [FRAC_BITS:0]      sc;
        logic [FRAC_BITS:0]      tc;
        mprod_t [2:0]            m1;
        mprod_t [2:0]            m2;
        diff_t  [2:0]            diff;
        logic [2:0][2*PTW-1:0]   sq;
        logic [RMW-1:0]          rem;
        logic [RTW-1:0]          root;
        logic [GAP_W-1:0]        gap;
    } dist_stage_t;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;
    dist_stage_t   st_reg  [NS];
    dist_stage_t   st_next [NS];

    function automatic logic [FRAC_BITS:0] clamp_unit(input param_t p);
        logic signed [CLW-1:0] w;
        logic [FRAC_BITS:0]    r;
        w = CLW'(p);
        if (w[CLW-1])
        begin
            r = '0;
        end
        else if (w > ONE_W)
        begin
            r = (FRAC_BITS+1)'(ONE_W);
        end
        else
        begin
            r = (FRAC_BITS+1)'(w);
        end
        return r;
    endfunction

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_comb
    begin
        logic signed [DFW-1:0] df;
        logic [SQW-1:0]        sm;
        logic [RMW-1:0]        tr;
        st_next[0]      = '0;
        st_next[0].geom = in_data.geom;
        st_next[0].pa   = in_data.param_a;
        st_next[0].pb   = in_data.param_b;
        st_next[0].par  = in_data.parallel;
        st_next[0].sc   = clamp_unit(in_data.param_a);
        st_next[0].tc   = clamp_unit(in_data.param_b);
        for (int k = 1; k < NS; k++)
        begin
            st_next[k] = st_reg[k-1];
            if (k == 1)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    st_next[k].m1[i] = MW'($signed(st_reg[k-1].geom.d1[i]))
                                     * MW'($signed({1'b0, st_reg[k-1].sc}));
                    st_next[k].m2[i] = MW'($signed(st_reg[k-1].geom.d2[i]))
                                     * MW'($signed({1'b0, st_reg[k-1].tc}));
                end
            end
            else if (k == 2)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    df = ((DFW'($signed(st_reg[k-1].geom.o2[i])) <<< FRAC_BITS)
                          + DFW'($signed(st_reg[k-1].m2[i])))
                       - ((DFW'($signed(st_reg[k-1].geom.o1[i])) <<< FRAC_BITS)
                          + DFW'($signed(st_reg[k-1].m1[i])));
                    st_next[k].diff[i] = PTW'(df);
                end
            end
            else if (k == 3)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    st_next[k].sq[i] = (2*PTW)'((2*PTW)'($signed(st_reg[k-1].diff[i]))
                                              * (2*PTW)'($signed(st_reg[k-1].diff[i])));
                end
            end
            else if (k == 4)
            begin
                sm = SQW'(st_reg[k-1].sq[0]) + SQW'(st_reg[k-1].sq[1])
                   + SQW'(st_reg[k-1].sq[2]);
                st_next[k].rem  = RMW'(RADW'(sm >> SH));
                st_next[k].root = '0;
            end
            else if (k < NS - 1)
            begin
                tr = (RMW'(st_reg[k-1].root) << (RTW + 5 - k))
                   | (RMW'(1) << (2 * (RTW + 4 - k)));
                if (st_reg[k-1].rem >= tr)
                begin
                    st_next[k].rem             = st_reg[k-1].rem - tr;
                    st_next[k].root[RTW+4-k]   = 1'b1;
                end
            end
            else
            begin
                st_next[k].gap = (GXW'(st_reg[k-1].root) > GXW'(GMAX)) ? GMAX
                               : GAP_W'(st_reg[k-1].root);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_comb
    begin
        out_data.param_a    = st_reg[NS-1].pa;
        out_data.param_b    = st_reg[NS-1].pb;
        out_data.gap_length = st_reg[NS-1].gap;
        out_data.parallel   = st_reg[NS-1].par;
    end

endmodule
`default_nettype wire

// ===== tb/sca_checker.sv =====
`default_nettype none
module sca_checker (
    input  wire       clk,
    input  wire       rst_n,
    sca_seg_if        segs,
    sca_res_if        result,
    output int        fails,
    output int        pending,
    output int        checked,
    output int        parallel_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sca_pkg::*;

    typedef logic signed [127:0] wide_t;

    result_t expected_q[$];

    function automatic param_t quotient_q16(wide_t num, wide_t den);
        logic        neg;
        logic [159:0] mag;
        logic [159:0] q;
        neg = num < 0;
        mag = neg ? 160'(-num) : 160'(num);
        q   = (mag << FRAC_BITS) / 160'(den);
        if (!neg)
        begin
            if (q > 160'((1 << (PARAM_W - 1)) - 1))
                q = 160'((1 << (PARAM_W - 1)) - 1);
            return param_t'(q);
        end
        if (q > 160'(1 << (PARAM_W - 1)))
            q = 160'(1 << (PARAM_W - 1));
        return param_t'(-q);
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [129:0] cc;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            cc = {66'd0, c} * {66'd0, c};
            if (cc <= {2'b00, s})
                r = c;
        end
        return r;
    endfunction

    function automatic wide_t unit_clamp(param_t p);
        if (p > param_t'(1 << FRAC_BITS))
            return wide_t'(1 << FRAC_BITS);
        return p > 0 ? wide_t'(p) : wide_t'(0);
    endfunction

    function automatic result_t closest_approach(seg_pair_t p);
        wide_t   o1 [3];
        wide_t   o2 [3];
        wide_t   d1 [3];
        wide_t   d2 [3];
        wide_t   v0 [3];
        wide_t   a11, a22, a12, v1, v2, den, sc, tc, diff, sum;
        wide_t   one;
        logic [63:0] g;
        result_t r;
        one = wide_t'(1 << FRAC_BITS);
        o1[0] = p.a_start_x;  o1[1] = p.a_start_y;  o1[2] = p.a_start_z;
        o2[0] = p.b_start_x;  o2[1] = p.b_start_y;  o2[2] = p.b_start_z;
        d1[0] = wide_t'(p.a_end_x) - o1[0];
        d1[1] = wide_t'(p.a_end_y) - o1[1];
        d1[2] = wide_t'(p.a_end_z) - o1[2];
        d2[0] = wide_t'(p.b_end_x) - o2[0];
        d2[1] = wide_t'(p.b_end_y) - o2[1];
        d2[2] = wide_t'(p.b_end_z) - o2[2];
        a11 = 0; a22 = 0; a12 = 0; v1 = 0; v2 = 0; sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            v0[i] = o2[i] - o1[i];
            a11 += d1[i] * d1[i];
            a22 += d2[i] * d2[i];
            a12 += d1[i] * d2[i];
            v1  += v0[i] * d1[i];
            v2  += v0[i] * d2[i];
        end
        den = a11 * a22 - a12 * a12;
        r.parallel = (den == 0);
        r.param_a  = '0;
        r.param_b  = '0;
        if (!r.parallel)
        begin
            r.param_a = quotient_q16(v1 * a22 - v2 * a12, den);
            r.param_b = quotient_q16(v1 * a12 - v2 * a11, den);
        end
        sc = unit_clamp(r.param_a);
        tc = unit_clamp(r.param_b);
        for (int i = 0; i < 3; i++)
        begin
            diff = (o2[i] * one + d2[i] * tc) - (o1[i] * one + d1[i] * sc);
            sum += diff * diff;
        end
        g = root_floor(128'(sum) >> SH);
        if (g > 64'((1 << GAP_W) - 1))
            g = 64'((1 << GAP_W) - 1);
        r.gap_length = g[GAP_W-1:0];
        return r;
    endfunction

    task automatic report(string field, longint unsigned want, longint unsigned got);
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
        fails++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        seg_pair_t p;
        result_t   e;
        if (!rst_n)
        begin
            fails = 0;
            checked = 0;
            parallel_seen = 0;
        end
        if (rst_n && segs.valid && segs.ready)
        begin
            p = {segs.a_start_x, segs.a_start_y, segs.a_start_z,
                 segs.a_end_x, segs.a_end_y, segs.a_end_z,
                 segs.b_start_x, segs.b_start_y, segs.b_start_z,
                 segs.b_end_x, segs.b_end_y, segs.b_end_z};
            expected_q.push_back(closest_approach(p));
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t result item arrived with nothing expected", $time);
                fails++;
            end
            else
            begin
                e = expected_q.pop_front();
                checked++;
                if (e.parallel)
                    parallel_seen++;
                if (result.param_a !== e.param_a)
                    report("param_a", e.param_a, result.param_a);
                if (result.param_b !== e.param_b)
                    report("param_b", e.param_b, result.param_b);
                if (result.gap_length !== e.gap_length)
                    report("gap_length", e.gap_length, result.gap_length);
                if (result.parallel !== e.parallel)
                    report("parallel", e.parallel, result.parallel);
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/segment_closest_approach_top_tb.sv =====
`default_nettype none
module segment_closest_approach_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sca_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    int   fails, pending, checked, parallel_seen;
    int   idle_cycles = 0;
    int   ready_stall = 0;

    sca_seg_if segs ();
    sca_res_if result ();

    segment_closest_approach_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .segs   (segs),
        .result (result)
    );

    sca_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .segs          (segs),
        .result        (result),
        .fails         (fails),
        .pending       (pending),
        .checked       (checked),
        .parallel_seen (parallel_seen)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            ready_stall  <= 0;
        end
        else if (ready_stall > 0)
        begin
            result.ready <= 1'b0;
            ready_stall  <= ready_stall - 1;
        end
        else
        begin
            result.ready <= 1'b1;
            ready_stall  <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((segs.valid && segs.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic seg_pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                            int cx, int cy, int cz, int ex, int ey, int ez);
        seg_pair_t p;
        p.a_start_x = coord_t'(ax);  p.a_start_y = coord_t'(ay);  p.a_start_z = coord_t'(az);
        p.a_end_x   = coord_t'(bx);  p.a_end_y   = coord_t'(by);  p.a_end_z   = coord_t'(bz);
        p.b_start_x = coord_t'(cx);  p.b_start_y = coord_t'(cy);  p.b_start_z = coord_t'(cz);
        p.b_end_x   = coord_t'(ex);  p.b_end_y   = coord_t'(ey);  p.b_end_z   = coord_t'(ez);
        return p;
    endfunction

    task automatic send_pair(seg_pair_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            segs.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        segs.valid     <= 1'b1;
        segs.a_start_x <= p.a_start_x;  segs.a_start_y <= p.a_start_y;
        segs.a_start_z <= p.a_start_z;  segs.a_end_x   <= p.a_end_x;
        segs.a_end_y   <= p.a_end_y;    segs.a_end_z   <= p.a_end_z;
        segs.b_start_x <= p.b_start_x;  segs.b_start_y <= p.b_start_y;
        segs.b_start_z <= p.b_start_z;  segs.b_end_x   <= p.b_end_x;
        segs.b_end_y   <= p.b_end_y;    segs.b_end_z   <= p.b_end_z;
        do
            @(posedge clk);
        while (!segs.ready);
    endtask

    function automatic int any_coord();
        return $urandom_range(0, 65535) - 32768;
    endfunction

    function automatic int near_coord();
        return $urandom_range(0, 200) - 100;
    endfunction

    function automatic seg_pair_t random_pair();
        int kind, k, sx, sy, sz, dx, dy, dz;
        int c [12];
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            c[i] = (kind >= 4 && kind <= 5) ? near_coord() : any_coord();
        sx = $urandom_range(0, 100) - 50;
        sy = $urandom_range(0, 100) - 50;
        sz = $urandom_range(0, 100) - 50;
        case (kind)
            6:
            begin
                k = $urandom_range(0, 6) - 3;
                c[3] = c[0] + sx;  c[4] = c[1] + sy;  c[5] = c[2] + sz;
                c[9] = c[6] + k * sx;  c[10] = c[7] + k * sy;  c[11] = c[8] + k * sz;
            end
            7:
            begin
                c[3] = c[0];  c[4] = c[1];  c[5] = c[2];
                if ($urandom_range(0, 1))
                begin
                    c[9] = c[6];  c[10] = c[7];  c[11] = c[8];
                end
            end
            8:
            begin
                dx = $urandom_range(0, 20000) - 10000;
                dy = $urandom_range(0, 20000) - 10000;
                dz = $urandom_range(0, 20000) - 10000;
                c[3] = c[0] + dx;  c[4] = c[1] + dy;  c[5] = c[2] + dz;
                c[6] = c[0] + sx;  c[7] = c[1] + sy;  c[8] = c[2] + sz;
                c[9]  = c[6] + dx + $urandom_range(0, 2) - 1;
                c[10] = c[7] + dy + $urandom_range(0, 2) - 1;
                c[11] = c[8] + dz;
            end
            9:
            begin
                c[6] = c[3];  c[7] = c[4];  c[8] = c[5];
            end
            default:
            begin
            end
        endcase
        return make_pair(c[0], c[1], c[2], c[3], c[4], c[5],
                         c[6], c[7], c[8], c[9], c[10], c[11]);
    endfunction

    initial
    begin
        seg_pair_t directed [$];
        segs.valid     <= 1'b0;
        segs.a_start_x <= '0;  segs.a_start_y <= '0;  segs.a_start_z <= '0;
        segs.a_end_x   <= '0;  segs.a_end_y   <= '0;  segs.a_end_z   <= '0;
        segs.b_start_x <= '0;  segs.b_start_y <= '0;  segs.b_start_z <= '0;
        segs.b_end_x   <= '0;  segs.b_end_y   <= '0;  segs.b_end_z   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(-10, 0, 0, 10, 0, 0, 0, -10, 5, 0, 10, 5));
        directed.push_back(make_pair(0, 0, 0, 1, 0, 0, 100, -1, 3, 100, 1, 3));
        directed.push_back(make_pair(0, 0, 0, 1, 0, 0, 32767, -1, 0, 32767, 1, 1));
        directed.push_back(make_pair(0, 0, 0, 1, 0, 0, -32768, 1, 0, -32768, -1, 1));
        directed.push_back(make_pair(0, 0, 0, 5, 5, 5, 1, 2, 3, 11, 12, 13));
        directed.push_back(make_pair(0, 0, 0, 4, 0, 0, 6, 0, 0, -2, 0, 0));
        directed.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, -32768, -32768));
        directed.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                     32767, -32768, 32767, -32768, 32767, -32768));
        directed.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768,
                                     -32768, 32767, -32768, 32767, -32768, 32767));
        directed.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                     32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32767,
                                     32767, 32767, 32767, 32766, 32767, 32767));
        directed.push_back(make_pair(3, 4, 5, 3, 4, 5, -7, 2, 9, 8, -1, 0));
        directed.push_back(make_pair(0, 0, 0, 10, 0, 0, 10, 0, 0, 10, 10, 0));
        directed.push_back(make_pair(0, 0, 0, 2, 0, 0, 5, 1, 0, 5, 2, 0));
        foreach (directed[i])
            send_pair(directed[i]);

        for (int n = 0; n < 550; n++)
        begin
            if (n % 100 == 0)
                calm <= (n % 200 == 100);
            send_pair(random_pair());
        end
        segs.valid <= 1'b0;
        calm <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Checked %0d result items from directed and random segment pairs,", checked);
        $display("%0d of them parallel or degenerate, with idling on both sides.", parallel_seen);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/sca_pkg.sv
src/sca_if.sv
src/sca_dot.sv
src/sca_div.sv
src/sca_dist.sv
src/segment_closest_approach_top.sv
tb/sca_checker.sv
tb/segment_closest_approach_top_tb.sv
